// File: sv/utf8_safe_truncating_copy_assert.svh
// Assertion macros used by the checker file of the truncating copy block.
`ifndef UTF8_SAFE_TRUNCATING_COPY_ASSERT_SVH
`define UTF8_SAFE_TRUNCATING_COPY_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define UTF8STC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("utf8stc: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define UTF8STC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("utf8stc: next-cycle check failed");

`endif

// File: sv/utf8stc_pkg.sv
// Package with shared types, constants and the byte classifier of the truncating copy.
`default_nettype none
package utf8stc_pkg;

	localparam int LEN_BITS_DEFAULT = 16;
	localparam int LEN_BITS_MIN = 8;
	localparam int LEN_BITS_MAX = 32;

	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;

	// Register word indexes on the configuration port.
	localparam logic REG_MAX_LEN = 1'b0;

	localparam logic [2:0] ONES_CAP = 3'd7;
	localparam logic [2:0] ONES_CONT = 3'd1;
	localparam logic [2:0] ONES_LEAD2 = 3'd2;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [7:0] data;
		logic [2:0] ones;
	} item_t;

	// Count of leading one bits, capped at seven (0xFE and 0xFF both give seven).
	function automatic logic [2:0] lead_ones(input logic [7:0] b);
		logic [2:0] n;
		logic       run;
		n = 3'd0;
		run = 1'b1;
		for (int i = 7; i >= 1; i--) begin
			if (run && b[i]) begin
				n = n + 3'd1;
			end else begin
				run = 1'b0;
			end
		end
		return n;
	endfunction

endpackage
`default_nettype wire

// File: sv/utf8stc_front.sv
// Front stage: accepts source bytes, classifies them and hands them to the queue.
`default_nettype none
module utf8stc_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [7:0]           src_byte,
	output logic                      push,
	output utf8stc_pkg::item_t        push_item,
	input  wire logic                 q_full
);

	logic               valid_s1;
	utf8stc_pkg::item_t item_s1;
	logic               take;

	assign push      = valid_s1 && !q_full;
	assign push_item = item_s1;
	assign in_stall  = valid_s1 && q_full;
	assign take      = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.data <= src_byte;
			item_s1.ones <= utf8stc_pkg::lead_ones(src_byte);
		end
	end

endmodule
`default_nettype wire

// File: sv/utf8stc_queue.sv
// Two-entry queue that decouples the classifier from the copy engine.
`default_nettype none
module utf8stc_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire utf8stc_pkg::item_t   push_item,
	output logic                      full,
	input  wire logic                 pop,
	output utf8stc_pkg::item_t        pop_item,
	output logic                      empty
);

	localparam int PTR_W = $clog2(utf8stc_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(utf8stc_pkg::QUEUE_DEPTH + 1);

	utf8stc_pkg::item_t slot_q [utf8stc_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full     = (count_q == CNT_W'(utf8stc_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(utf8stc_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(utf8stc_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

// File: sv/utf8stc_back.sv
// Copy engine: tracks length and character state and registers each result.
`default_nettype none
module utf8stc_back #(
	parameter int LEN_BITS = utf8stc_pkg::LEN_BITS_DEFAULT
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [15:0]        max_len,
	input  wire logic               q_empty,
	input  wire utf8stc_pkg::item_t q_item,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    wr_en,
	output logic [15:0]             wr_addr,
	output logic [7:0]              wr_data,
	output logic                    finished,
	output logic [15:0]             copied_len
);

	logic                stopped_q;
	logic [LEN_BITS-1:0] count_q;
	logic [LEN_BITS-1:0] start_q;
	logic [2:0]          pend_q;
	logic                out_valid_q;

	logic                stopped_d;
	logic [LEN_BITS-1:0] count_d;
	logic [LEN_BITS-1:0] start_d;
	logic [2:0]          pend_d;
	logic                en_d;
	logic [LEN_BITS-1:0] addr_d;
	logic [7:0]          data_d;
	logic                buf_full;
	logic                bad_lead;

	assign pop       = !q_empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	// The effective capacity is the smaller of max_len and the counter's top value.
	assign buf_full = (32'(count_q) >= 32'(max_len)) || (&count_q);
	assign bad_lead = (q_item.ones == utf8stc_pkg::ONES_CONT)
		|| (q_item.ones == utf8stc_pkg::ONES_CAP) || (q_item.data == 8'h00);

	always_comb begin
		stopped_d = stopped_q;
		count_d   = count_q;
		start_d   = start_q;
		pend_d    = pend_q;
		en_d      = 1'b0;
		addr_d    = '0;
		data_d    = 8'h00;
		if (stopped_q) begin
			en_d = 1'b0;
		end else if (pend_q == 3'd0) begin
			if (bad_lead || buf_full) begin
				stopped_d = 1'b1;
			end else begin
				en_d    = 1'b1;
				addr_d  = count_q;
				data_d  = q_item.data;
				start_d = count_q;
				count_d = count_q + LEN_BITS'(1);
				pend_d  = (q_item.ones >= utf8stc_pkg::ONES_LEAD2) ? q_item.ones - 3'd1 : 3'd0;
			end
		end else if (q_item.ones == utf8stc_pkg::ONES_CONT && !buf_full) begin
			en_d    = 1'b1;
			addr_d  = count_q;
			data_d  = q_item.data;
			count_d = count_q + LEN_BITS'(1);
			pend_d  = pend_q - 3'd1;
		end else begin
			// The character in progress is cut short: rewind and clear its first byte.
			en_d      = 1'b1;
			addr_d    = start_q;
			data_d    = 8'h00;
			count_d   = start_q;
			pend_d    = 3'd0;
			stopped_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stopped_q   <= 1'b0;
			count_q     <= '0;
			start_q     <= '0;
			pend_q      <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				stopped_q <= stopped_d;
				count_q   <= count_d;
				start_q   <= start_d;
				pend_q    <= pend_d;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			wr_en      <= en_d;
			wr_addr    <= 16'(addr_d);
			wr_data    <= data_d;
			finished   <= stopped_d;
			copied_len <= 16'(count_d);
		end
	end

endmodule
`default_nettype wire

// File: sv/utf8_safe_truncating_copy.sv
// Top level of the UTF-8 boundary-safe truncating copy with its register port.
//
//  channel   direction  handshake             payload
//  input     in         in_valid / in_stall   src_byte
//  output    out        out_valid / out_stall wr_en wr_addr wr_data finished copied_len
//  register  in         psel penable pwrite   paddr pwdata prdata (max_len at 0x0)
//
// One byte is taken per cycle while in_stall is low; a byte's result is offered once
// it has passed the classifier register, the queue and the result register, in that order.
// The copy engine does one state update per cycle while the queue holds a byte and the
// output is not stalled, so throughput is one per cycle under those conditions.
// Reset clears the copy state and sets max_len to zero; no clearing pass is needed.
// A stalled output holds its result while the queue keeps taking bytes until full.
`default_nettype none
module utf8_safe_truncating_copy #(
	parameter int LEN_BITS = utf8stc_pkg::LEN_BITS_DEFAULT
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [7:0]                          src_byte,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     wr_en,
	output logic [15:0]                              wr_addr,
	output logic [7:0]                               wr_data,
	output logic                                     finished,
	output logic [15:0]                              copied_len,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [utf8stc_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [utf8stc_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [utf8stc_pkg::CFG_DATA_W-1:0]       prdata,
	output logic                                     pready
);

	logic               max_len_sel;
	logic [15:0]        max_len_q;
	logic               push;
	utf8stc_pkg::item_t push_item;
	logic               q_full;
	logic               pop;
	utf8stc_pkg::item_t q_item;
	logic               q_empty;

	assign pready      = 1'b1;
	assign max_len_sel = (paddr[2] == utf8stc_pkg::REG_MAX_LEN);
	assign prdata      = max_len_sel ? utf8stc_pkg::CFG_DATA_W'(max_len_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= 16'd0;
		end else if (psel && penable && pwrite && pready && max_len_sel) begin
			max_len_q <= pwdata[15:0];
		end
	end

	utf8stc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.src_byte  (src_byte),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	utf8stc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_item  (q_item),
		.empty     (q_empty)
	);

	utf8stc_back #(
		.LEN_BITS (LEN_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.max_len    (max_len_q),
		.q_empty    (q_empty),
		.q_item     (q_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.finished   (finished),
		.copied_len (copied_len)
	);

endmodule
`default_nettype wire

// File: sv/utf8stc_checker.sv
// Port-level checker for the truncating copy, bound to the top level.
`default_nettype none
`include "utf8_safe_truncating_copy_assert.svh"
module utf8stc_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic        wr_en,
	input  wire logic [15:0] wr_addr,
	input  wire logic [7:0]  wr_data,
	input  wire logic        finished,
	input  wire logic [15:0] copied_len
);

	logic [41:0] result_bits;

	assign result_bits = {wr_en, wr_addr, wr_data, finished, copied_len};

	// A result without a write carries a zero address and zero data.
	`UTF8STC_ASSERT_NOW(a_idle_write_zero, out_valid && !wr_en, wr_addr == 16'd0 && wr_data == 8'h00)

	// A write that comes with the stop is always the rollback of a character start.
	`UTF8STC_ASSERT_NOW(a_rollback_shape, out_valid && wr_en && finished, wr_data == 8'h00 && wr_addr == copied_len)

	// An ordinary write advances the committed length to just past its address.
	`UTF8STC_ASSERT_NOW(a_write_advances, out_valid && wr_en && !finished, copied_len == 16'(wr_addr + 16'd1))

	// A stalled result stays offered and unchanged.
	`UTF8STC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result_bits))

endmodule

bind utf8_safe_truncating_copy utf8stc_checker u_utf8stc_checker (.*);
`default_nettype wire
